FILE: hdl/lookahead_subgoal_selector_defines.svh
// assertion macros shared by the lookahead subgoal selector rtl
`ifndef LOOKAHEAD_SUBGOAL_SELECTOR_DEFINES_SVH
`define LOOKAHEAD_SUBGOAL_SELECTOR_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define LSS_ASSERT_IMP(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define LSS_ASSERT_NXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

FILE: hdl/lss_pkg.sv
// types, codes and constants of the lookahead subgoal selector
`default_nettype none

package lss_pkg;

    // field and storage widths
    localparam int COORD_BITS   = 24;
    localparam int REG_BITS     = 24;
    localparam int IDX_BITS     = 12;
    localparam int MAX_POINTS   = 4096;
    localparam int CFG_IDX_BITS = 2;
    localparam int SQ_BITS      = 2 * COORD_BITS;
    localparam int DIST_BITS    = SQ_BITS + 1;
    localparam int THR_BITS     = 2 * (REG_BITS + 1);

    // highest waypoint index that the counter reaches
    localparam logic [IDX_BITS-1:0] IDX_MAX = IDX_BITS'(MAX_POINTS - 1);

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_GOAL_TOL    = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SUBGOAL_TOL = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HORIZON     = 2'd2;

    // register reset values
    localparam logic [REG_BITS-1:0] GOAL_TOL_RESET    = 24'd2048;
    localparam logic [REG_BITS-1:0] SUBGOAL_TOL_RESET = 24'd8192;
    localparam logic [REG_BITS-1:0] HORIZON_RESET     = 24'd12288;

    // operation codes
    localparam logic OP_BEGIN = 1'b0;
    localparam logic OP_POINT = 1'b1;

    // status codes
    localparam logic [1:0] ST_GOAL_REACHED = 2'd0;
    localparam logic [1:0] ST_NEAR_GOAL    = 2'd1;
    localparam logic [1:0] ST_PATH_POINT   = 2'd2;
    localparam logic [1:0] ST_NO_POINT     = 2'd3;

    // input beat
    typedef struct packed {
        logic                         operation;
        logic signed [COORD_BITS-1:0] robot_x;
        logic signed [COORD_BITS-1:0] robot_y;
        logic signed [COORD_BITS-1:0] goal_x;
        logic signed [COORD_BITS-1:0] goal_y;
        logic signed [COORD_BITS-1:0] point_x;
        logic signed [COORD_BITS-1:0] point_y;
        logic                         last_point;
    } cmd_t;

    // result beat
    typedef struct packed {
        logic [1:0]                   status;
        logic signed [COORD_BITS-1:0] subgoal_x;
        logic signed [COORD_BITS-1:0] subgoal_y;
        logic [IDX_BITS-1:0]          subgoal_index;
    } res_t;

    // absolute difference of two signed coordinates, always fits COORD_BITS unsigned
    function automatic logic [COORD_BITS-1:0] abs_diff(
        input logic signed [COORD_BITS-1:0] a,
        input logic signed [COORD_BITS-1:0] b
    );
        logic signed [COORD_BITS:0] d;
        logic signed [COORD_BITS:0] m;
        d = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
        m = -d;
        return d[COORD_BITS] ? m[COORD_BITS-1:0] : d[COORD_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: hdl/lookahead_subgoal_selector.sv
// lookahead subgoal selector: squared-distance goal test and ring search over waypoints
//
//  channel  dir  handshake            payload
//  cmd      in   cmd_valid/cmd_stall  lss_pkg::cmd_t
//  res      out  res_valid/res_stall  lss_pkg::res_t
//  cfg      in   cfg_we               cfg_index, cfg_data
//
// one beat per cycle while cmd_stall is low; a beat that closes a query raises res_valid
// (input register, then abs difference, squares, compare and update into the result register)
// cmd_stall rises only while the input register is full and a result waits under res_stall
// rst_n clears the registers to their reset values, the decided flag to one
// register squares are recomputed in the cycle after a write
`default_nettype none

module lookahead_subgoal_selector (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cmd_valid,
    output      logic                            cmd_stall,
    input  wire lss_pkg::cmd_t                   cmd,
    output      logic                            res_valid,
    input  wire logic                            res_stall,
    output      lss_pkg::res_t                   res,
    input  wire logic                            cfg_we,
    input  wire logic [lss_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  wire logic [lss_pkg::REG_BITS-1:0]     cfg_data
);

    `include "lookahead_subgoal_selector_defines.svh"

    localparam int CB = lss_pkg::COORD_BITS;
    localparam int RB = lss_pkg::REG_BITS;
    localparam int IB = lss_pkg::IDX_BITS;
    localparam int SB = lss_pkg::SQ_BITS;
    localparam int DB = lss_pkg::DIST_BITS;
    localparam int TB = lss_pkg::THR_BITS;

    // configuration registers
    logic [RB-1:0] goal_tol_reg;
    logic [RB-1:0] subgoal_tol_reg;
    logic [RB-1:0] horizon_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            goal_tol_reg    <= lss_pkg::GOAL_TOL_RESET;
            subgoal_tol_reg <= lss_pkg::SUBGOAL_TOL_RESET;
            horizon_reg     <= lss_pkg::HORIZON_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                lss_pkg::CFG_GOAL_TOL:    goal_tol_reg    <= cfg_data;
                lss_pkg::CFG_SUBGOAL_TOL: subgoal_tol_reg <= cfg_data;
                lss_pkg::CFG_HORIZON:     horizon_reg     <= cfg_data;
                default:                  ;
            endcase
        end
    end

    // squared thresholds, one multiplier each
    logic [RB:0]     ring_hi;
    logic [RB-1:0]   ring_lo;
    logic [2*RB-1:0] goal_sq;
    logic [2*RB-1:0] horizon_sq;
    logic [2*RB+1:0] hi_sq;
    logic [2*RB-1:0] lo_sq;
    logic [TB-1:0]   goal2_reg;
    logic [TB-1:0]   horizon2_reg;
    logic [TB-1:0]   hi2_reg;
    logic [TB-1:0]   lo2_reg;
    logic            lo_on_reg;

    assign ring_hi    = {1'b0, horizon_reg} + {1'b0, subgoal_tol_reg};
    assign ring_lo    = horizon_reg - subgoal_tol_reg;
    assign goal_sq    = goal_tol_reg * goal_tol_reg;
    assign horizon_sq = horizon_reg * horizon_reg;
    assign hi_sq      = ring_hi * ring_hi;
    assign lo_sq      = ring_lo * ring_lo;

    always_ff @(posedge clk)
    begin
        goal2_reg    <= TB'(goal_sq);
        horizon2_reg <= TB'(horizon_sq);
        hi2_reg      <= TB'(hi_sq);
        lo2_reg      <= TB'(lo_sq);
        lo_on_reg    <= (horizon_reg >= subgoal_tol_reg);
    end

    // handshake: the input register moves on unless a result waits under stall
    logic v0_reg, res_valid_reg;
    logic leave0;

    assign leave0    = v0_reg && (!res_valid_reg || !res_stall);
    assign cmd_stall = v0_reg && !leave0;

    // input register and robot position
    lss_pkg::cmd_t        cmd_reg;
    logic signed [CB-1:0] robot_pos_x_reg;
    logic signed [CB-1:0] robot_pos_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg          <= 1'b0;
            robot_pos_x_reg <= '0;
            robot_pos_y_reg <= '0;
        end
        else
        begin
            if (!cmd_stall)
            begin
                v0_reg <= cmd_valid;
            end
            if (leave0 && cmd_reg.operation == lss_pkg::OP_BEGIN)
            begin
                robot_pos_x_reg <= cmd_reg.robot_x;
                robot_pos_y_reg <= cmd_reg.robot_y;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_valid && !cmd_stall)
        begin
            cmd_reg <= cmd;
        end
    end

    // pick operands, absolute differences and their squares
    logic signed [CB-1:0] ref_x, ref_y, tgt_x, tgt_y;
    logic [CB-1:0]        dx, dy;
    logic [SB-1:0]        sx, sy;

    always_comb
    begin
        if (cmd_reg.operation == lss_pkg::OP_BEGIN)
        begin
            ref_x = cmd_reg.robot_x;
            ref_y = cmd_reg.robot_y;
            tgt_x = cmd_reg.goal_x;
            tgt_y = cmd_reg.goal_y;
        end
        else
        begin
            ref_x = robot_pos_x_reg;
            ref_y = robot_pos_y_reg;
            tgt_x = cmd_reg.point_x;
            tgt_y = cmd_reg.point_y;
        end
    end

    assign dx = lss_pkg::abs_diff(ref_x, tgt_x);
    assign dy = lss_pkg::abs_diff(ref_y, tgt_y);
    assign sx = dx * dx;
    assign sy = dy * dy;

    // compare, track the best ring point, form the result
    logic                 decided_reg, decided_next;
    logic [IB-1:0]        counter_reg, counter_next;
    logic [IB-1:0]        best_idx_reg, best_idx_next;
    logic signed [CB-1:0] best_x_reg, best_x_next;
    logic signed [CB-1:0] best_y_reg, best_y_next;
    logic [DB-1:0]        dist2;
    logic [TB-1:0]        dist2_w;
    logic                 in_ring, fresh, emit;
    lss_pkg::res_t        res_reg, res_next;

    assign dist2   = {1'b0, sx} + {1'b0, sy};
    assign dist2_w = TB'(dist2);
    assign in_ring = (dist2_w < hi2_reg) && (!lo_on_reg || dist2_w > lo2_reg);
    assign fresh   = (counter_reg < lss_pkg::IDX_MAX) || (best_idx_reg < counter_reg);

    always_comb
    begin
        decided_next  = decided_reg;
        counter_next  = counter_reg;
        best_idx_next = best_idx_reg;
        best_x_next   = best_x_reg;
        best_y_next   = best_y_reg;
        emit          = 1'b0;
        res_next      = '0;
        if (leave0)
        begin
            if (cmd_reg.operation == lss_pkg::OP_BEGIN)
            begin
                if (dist2_w <= goal2_reg)
                begin
                    decided_next    = 1'b1;
                    emit            = 1'b1;
                    res_next.status = lss_pkg::ST_GOAL_REACHED;
                end
                else if (dist2_w < horizon2_reg)
                begin
                    decided_next       = 1'b1;
                    emit               = 1'b1;
                    res_next.status    = lss_pkg::ST_NEAR_GOAL;
                    res_next.subgoal_x = tgt_x;
                    res_next.subgoal_y = tgt_y;
                end
                else
                begin
                    decided_next  = 1'b0;
                    counter_next  = '0;
                    best_idx_next = '0;
                    best_x_next   = '0;
                    best_y_next   = '0;
                end
            end
            else if (!decided_reg)
            begin
                if (fresh && in_ring && counter_reg != '0 && counter_reg > best_idx_reg)
                begin
                    best_idx_next = counter_reg;
                    best_x_next   = tgt_x;
                    best_y_next   = tgt_y;
                end
                if (counter_reg < lss_pkg::IDX_MAX)
                begin
                    counter_next = counter_reg + 1'b1;
                end
                if (cmd_reg.last_point)
                begin
                    decided_next = 1'b1;
                    emit         = 1'b1;
                    if (best_idx_next != '0)
                    begin
                        res_next.status        = lss_pkg::ST_PATH_POINT;
                        res_next.subgoal_x     = best_x_next;
                        res_next.subgoal_y     = best_y_next;
                        res_next.subgoal_index = best_idx_next;
                    end
                    else
                    begin
                        res_next.status = lss_pkg::ST_NO_POINT;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decided_reg   <= 1'b1;
            counter_reg   <= '0;
            best_idx_reg  <= '0;
            best_x_reg    <= '0;
            best_y_reg    <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            decided_reg  <= decided_next;
            counter_reg  <= counter_next;
            best_idx_reg <= best_idx_next;
            best_x_reg   <= best_x_next;
            best_y_reg   <= best_y_next;
            if (emit)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // checks on flow and result contents
    `LSS_ASSERT_IMP(a_stall_full, cmd_stall,
        v0_reg && res_valid_reg && res_stall,
        "cmd stalled while the result register is free")
    `LSS_ASSERT_IMP(a_reached_zero,
        res_valid && res.status == lss_pkg::ST_GOAL_REACHED,
        res.subgoal_x == '0 && res.subgoal_y == '0 && res.subgoal_index == '0,
        "goal reached beat carries a nonzero subgoal")
    `LSS_ASSERT_IMP(a_path_index, res_valid && res.status == lss_pkg::ST_PATH_POINT,
        res.subgoal_index != '0, "path point beat with index zero")
    `LSS_ASSERT_NXT(a_emit_decides, emit, decided_reg,
        "result issued without closing the query")

endmodule

`default_nettype wire

FILE: dv/lookahead_subgoal_selector_tb.sv
// testbench for the lookahead subgoal selector: directed and random paths, built-in predictor
`timescale 1ns / 100ps

module lookahead_subgoal_selector_tb;

    localparam int C_MIN          = -8388608;
    localparam int C_MAX          = 8388607;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int REPORT_LIMIT   = 10;
    localparam int CB             = lss_pkg::COORD_BITS;
    localparam int RB             = lss_pkg::REG_BITS;
    localparam int XB             = lss_pkg::CFG_IDX_BITS;

    // unused register slot, writes there must be dropped
    localparam logic [XB-1:0] CFG_UNUSED = 2'd3;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    logic            clk       = 1'b0;
    logic            rst_n     = 1'b0;
    logic            cmd_valid = 1'b0;
    logic            cmd_stall;
    lss_pkg::cmd_t   cmd       = '0;
    logic            res_valid;
    logic            res_stall = 1'b0;
    lss_pkg::res_t   res;
    logic            cfg_we    = 1'b0;
    logic [XB-1:0]   cfg_index = '0;
    logic [RB-1:0]   cfg_data  = '0;

    // idling controls
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    // predictor copy of registers and search state
    logic [RB-1:0]                 goal_tol_q   = lss_pkg::GOAL_TOL_RESET;
    logic [RB-1:0]                 sub_tol_q    = lss_pkg::SUBGOAL_TOL_RESET;
    logic [RB-1:0]                 horizon_q    = lss_pkg::HORIZON_RESET;
    logic signed [CB-1:0]          robot_x_q    = '0;
    logic signed [CB-1:0]          robot_y_q    = '0;
    logic                          query_done   = 1'b1;
    logic [lss_pkg::IDX_BITS-1:0]  waypoint_idx = '0;
    logic [lss_pkg::IDX_BITS-1:0]  best_idx     = '0;
    logic signed [CB-1:0]          best_x_q     = '0;
    logic signed [CB-1:0]          best_y_q     = '0;

    lss_pkg::res_t pending_subgoals[$];
    int   items_used     = 0;
    int   mismatch_count = 0;
    int   results_seen   = 0;
    int   quiet_cycles   = 0;

    lookahead_subgoal_selector u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // receiver stall pattern
    always @(negedge clk)
    begin
        res_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
    end

    // exact squared distance between two points
    function automatic logic [63:0] sq_dist(
        input logic signed [CB-1:0] ax,
        input logic signed [CB-1:0] ay,
        input logic signed [CB-1:0] bx,
        input logic signed [CB-1:0] by
    );
        logic signed [CB:0] ex;
        logic signed [CB:0] ey;
        logic [63:0]        ux;
        logic [63:0]        uy;
        ex = ax - bx;
        ey = ay - by;
        ux = ex[CB] ? 64'(-ex) : 64'(ex);
        uy = ey[CB] ? 64'(-ey) : 64'(ey);
        return ux * ux + uy * uy;
    endfunction

    function automatic int rand_signed(input int bound);
        return int'($urandom_range(0, 2 * bound)) - bound;
    endfunction

    // begin beat, waypoint fields filled with noise
    function automatic lss_pkg::cmd_t make_begin(input int rx, input int ry,
                                                 input int gx, input int gy);
        lss_pkg::cmd_t c;
        c.operation  = lss_pkg::OP_BEGIN;
        c.robot_x    = rx[CB-1:0];
        c.robot_y    = ry[CB-1:0];
        c.goal_x     = gx[CB-1:0];
        c.goal_y     = gy[CB-1:0];
        c.point_x    = CB'($urandom);
        c.point_y    = CB'($urandom);
        c.last_point = 1'($urandom);
        return c;
    endfunction

    // waypoint beat, position fields filled with noise
    function automatic lss_pkg::cmd_t make_point(input int px, input int py, input logic last);
        lss_pkg::cmd_t c;
        c.operation  = lss_pkg::OP_POINT;
        c.robot_x    = CB'($urandom);
        c.robot_y    = CB'($urandom);
        c.goal_x     = CB'($urandom);
        c.goal_y     = CB'($urandom);
        c.point_x    = px[CB-1:0];
        c.point_y    = py[CB-1:0];
        c.last_point = last;
        return c;
    endfunction

    // work out the subgoal, if any, that an accepted beat produces
    task automatic predict_subgoal(input lss_pkg::cmd_t c);
        logic [63:0]   d;
        logic [63:0]   outer;
        logic [63:0]   inner;
        logic          in_ring;
        lss_pkg::res_t r;
        r = '0;
        if (c.operation == lss_pkg::OP_BEGIN)
        begin
            items_used++;
            robot_x_q = c.robot_x;
            robot_y_q = c.robot_y;
            d = sq_dist(c.robot_x, c.robot_y, c.goal_x, c.goal_y);
            if (d <= 64'(goal_tol_q) * 64'(goal_tol_q))
            begin
                query_done = 1'b1;
                r.status   = lss_pkg::ST_GOAL_REACHED;
                pending_subgoals = {pending_subgoals, r};
            end
            else if (d < 64'(horizon_q) * 64'(horizon_q))
            begin
                query_done  = 1'b1;
                r.status    = lss_pkg::ST_NEAR_GOAL;
                r.subgoal_x = c.goal_x;
                r.subgoal_y = c.goal_y;
                pending_subgoals = {pending_subgoals, r};
            end
            else
            begin
                query_done   = 1'b0;
                waypoint_idx = '0;
                best_idx     = '0;
                best_x_q     = '0;
                best_y_q     = '0;
            end
        end
        else if (!query_done)
        begin
            items_used++;
            d = sq_dist(robot_x_q, robot_y_q, c.point_x, c.point_y);
            outer   = 64'(horizon_q) + 64'(sub_tol_q);
            in_ring = d < outer * outer;
            // inner bound only exists when the horizon covers the tolerance
            if (horizon_q >= sub_tol_q)
            begin
                inner   = 64'(horizon_q - sub_tol_q);
                in_ring = in_ring && (d > inner * inner);
            end
            if (in_ring && waypoint_idx != 0 && waypoint_idx > best_idx)
            begin
                best_idx = waypoint_idx;
                best_x_q = c.point_x;
                best_y_q = c.point_y;
            end
            if (waypoint_idx != lss_pkg::IDX_MAX)
                waypoint_idx++;
            if (c.last_point)
            begin
                query_done = 1'b1;
                if (best_idx != 0)
                begin
                    r.status        = lss_pkg::ST_PATH_POINT;
                    r.subgoal_x     = best_x_q;
                    r.subgoal_y     = best_y_q;
                    r.subgoal_index = best_idx;
                end
                else
                    r.status = lss_pkg::ST_NO_POINT;
                pending_subgoals = {pending_subgoals, r};
            end
        end
    endtask

    // send one beat, with random idle cycles ahead of it
    task automatic send_cmd(input lss_pkg::cmd_t c);
        @(negedge clk);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            cmd_valid = 1'b0;
            @(negedge clk);
        end
        cmd       = c;
        cmd_valid = 1'b1;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        predict_subgoal(c);
    endtask

    // hold off until every expected result is out and the pipe is empty
    task automatic wait_results_drained();
        @(negedge clk);
        cmd_valid = 1'b0;
        while (pending_subgoals.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_register(input logic [XB-1:0] idx, input logic [RB-1:0] val);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            lss_pkg::CFG_GOAL_TOL:    goal_tol_q = val;
            lss_pkg::CFG_SUBGOAL_TOL: sub_tol_q  = val;
            lss_pkg::CFG_HORIZON:     horizon_q  = val;
            default:                  ;
        endcase
    endtask

    // drain, then load all three limits and let the squares settle
    task automatic load_limits(input logic [RB-1:0] g, input logic [RB-1:0] t,
                               input logic [RB-1:0] h);
        wait_results_drained();
        write_register(lss_pkg::CFG_GOAL_TOL, g);
        write_register(lss_pkg::CFG_SUBGOAL_TOL, t);
        write_register(lss_pkg::CFG_HORIZON, h);
        repeat (2) @(negedge clk);
    endtask

    task automatic set_idling(input idle_mode_t mode);
        case (mode)
            IDLE_NONE:     begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            IDLE_SENDER:   begin send_idle_pct = 84; recv_stall_pct = 0;  end
            IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 84; end
            default:       begin send_idle_pct = 6;  recv_stall_pct = 6;  end
        endcase
    endtask

    // goal tests, ring edges, ignored waypoints, coordinate extremes
    task automatic test_goal_and_ring_cases();
        set_idling(IDLE_NONE);
        // goal on the robot, then exactly on the tolerance radius
        send_cmd(make_begin(0, 0, 0, 0));
        send_cmd(make_begin(100, -100, 2148, -100));
        // near goal
        send_cmd(make_begin(0, 0, 2049, 0));
        // waypoint while no query is open
        send_cmd(make_point(5000, 0, 1'b1));
        // goal exactly at the horizon opens a path, ring edges excluded
        send_cmd(make_begin(0, 0, 12288, 0));
        send_cmd(make_point(8000, 0, 1'b0));
        send_cmd(make_point(4096, 0, 1'b0));
        send_cmd(make_point(20480, 0, 1'b0));
        send_cmd(make_point(0, -3, 1'b1));
        // corner to corner, pick the highest index in the ring
        send_cmd(make_begin(C_MIN, C_MIN, C_MAX, C_MAX));
        send_cmd(make_point(C_MIN + 10000, C_MIN, 1'b0));
        send_cmd(make_point(C_MIN, C_MIN + 10000, 1'b0));
        send_cmd(make_point(C_MAX, C_MAX, 1'b0));
        send_cmd(make_point(C_MIN + 5000, C_MIN + 5000, 1'b0));
        send_cmd(make_point(C_MIN, C_MIN, 1'b1));
        // other corners, just inside the outer and inner ring edges
        send_cmd(make_begin(C_MAX, C_MIN, C_MIN, C_MAX));
        send_cmd(make_point(C_MAX - 20479, C_MIN, 1'b0));
        send_cmd(make_point(C_MAX, C_MIN + 20479, 1'b0));
        send_cmd(make_point(C_MAX - 4097, C_MIN, 1'b1));
        // a new begin cuts an open path short
        send_cmd(make_begin(0, 0, 50000, 0));
        send_cmd(make_point(8000, 0, 1'b0));
        send_cmd(make_begin(7, 7, 7, 7));
        send_cmd(make_point(9000, 0, 1'b1));
    endtask

    // zero and full-scale limits, horizon below tolerance, dropped index
    task automatic test_register_extremes();
        set_idling(IDLE_SENDER);
        wait_results_drained();
        write_register(CFG_UNUSED, 24'hABCDEF);
        load_limits(24'd0, 24'd0, 24'd0);
        send_cmd(make_begin(0, 0, 0, 0));
        send_cmd(make_begin(0, 0, 1, 0));
        send_cmd(make_point(0, 0, 1'b0));
        send_cmd(make_point(5, 5, 1'b1));

        load_limits(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
        send_cmd(make_begin(0, 0, C_MAX, C_MAX));
        send_cmd(make_begin(C_MIN, C_MIN, C_MAX, C_MAX));
        send_cmd(make_point(C_MAX, C_MIN, 1'b0));
        send_cmd(make_point(C_MIN, C_MIN, 1'b0));
        send_cmd(make_point(C_MAX, C_MAX, 1'b0));
        send_cmd(make_point(0, 0, 1'b1));

        // ring with no inner bound
        load_limits(24'd0, 24'hFFFFFF, 24'd0);
        send_cmd(make_begin(0, 0, 1, 0));
        send_cmd(make_point(3, 3, 1'b0));
        send_cmd(make_point(0, 0, 1'b0));
        send_cmd(make_point(C_MAX, C_MIN, 1'b1));

        // thinnest ring at full horizon
        load_limits(24'd1, 24'd1, 24'hFFFFFF);
        send_cmd(make_begin(C_MIN, 0, C_MAX, 0));
        send_cmd(make_point(C_MAX, 0, 1'b0));
        send_cmd(make_point(C_MAX, 0, 1'b0));
        send_cmd(make_point(C_MAX, 1, 1'b1));
    endtask

    // path longer than the index range, counter must hold at its top
    task automatic test_index_saturation();
        int  k;
        logic last;
        load_limits(lss_pkg::GOAL_TOL_RESET, lss_pkg::SUBGOAL_TOL_RESET, lss_pkg::HORIZON_RESET);
        set_idling(IDLE_BOTH);
        send_cmd(make_begin(0, 0, 100000, 0));
        for (k = 0; k < lss_pkg::MAX_POINTS + 4; k++)
        begin
            last = (k == lss_pkg::MAX_POINTS + 3);
            if ($urandom_range(9) == 0 || k >= lss_pkg::MAX_POINTS - 2)
                send_cmd(make_point(6000 + int'($urandom_range(10000)),
                                    int'($urandom_range(100)), last));
            else
                send_cmd(make_point(int'($urandom_range(1000)), 0, last));
        end
    endtask

    // mostly well-formed queries with random geometry, some noise and cut paths
    task automatic test_random_paths(input int target, input logic [RB-1:0] g,
                                     input logic [RB-1:0] t, input logic [RB-1:0] h,
                                     input idle_mode_t mode);
        int   first;
        int   gi;
        int   ti;
        int   hi;
        int   rx;
        int   ry;
        int   ox;
        int   oy;
        int   n;
        int   k;
        int   pick;
        logic paused;
        lss_pkg::cmd_t c;
        load_limits(g, t, h);
        set_idling(mode);
        first  = items_used;
        paused = 1'b0;
        gi     = int'(g);
        ti     = int'(t);
        hi     = int'(h);
        while (items_used - first < target)
        begin
            // sender holds off once until every result is back
            if (!paused && items_used - first >= target / 2)
            begin
                wait_results_drained();
                paused = 1'b1;
            end
            pick = $urandom_range(99);
            if (pick < 80)
            begin
                rx   = rand_signed(1 << 22);
                ry   = rand_signed(1 << 22);
                pick = $urandom_range(99);
                if (pick < 10)
                begin
                    ox = rand_signed(gi / 2);
                    oy = rand_signed(gi / 2);
                end
                else if (pick < 25 && hi > gi + 2)
                begin
                    ox = int'($urandom_range(gi + 1, hi - 1));
                    ox = $urandom_range(1) ? ox : -ox;
                    oy = 0;
                end
                else
                begin
                    ox = hi + gi + int'($urandom_range(hi + 1));
                    ox = $urandom_range(1) ? ox : -ox;
                    oy = rand_signed(hi);
                end
                send_cmd(make_begin(rx, ry, rx + ox, ry + oy));
                if (!query_done)
                begin
                    n = ($urandom_range(9) == 0) ? $urandom_range(1, 60) : $urandom_range(1, 16);
                    for (k = 1; k <= n; k++)
                        send_cmd(make_point(rx + rand_signed(hi + ti + 64),
                                            ry + rand_signed(hi + ti + 64),
                                            (k == n) && ($urandom_range(19) != 0)));
                end
            end
            else if (pick < 92)
            begin
                // any beat at all
                c.operation  = 1'($urandom);
                c.robot_x    = CB'($urandom);
                c.robot_y    = CB'($urandom);
                c.goal_x     = CB'($urandom);
                c.goal_y     = CB'($urandom);
                c.point_x    = CB'($urandom);
                c.point_y    = CB'($urandom);
                c.last_point = 1'($urandom);
                send_cmd(c);
            end
            else
                send_cmd(make_point(int'($urandom), int'($urandom), 1'($urandom)));
        end
    endtask

    // result check against the oldest expected subgoal
    always @(posedge clk)
    begin
        lss_pkg::res_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            results_seen++;
            if (pending_subgoals.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("result %0d not expected: status %0d x %0d y %0d index %0d",
                             results_seen, res.status, res.subgoal_x, res.subgoal_y,
                             res.subgoal_index);
            end
            else
            begin
                want = pending_subgoals.pop_front();
                if (res.status !== want.status || res.subgoal_x !== want.subgoal_x ||
                    res.subgoal_y !== want.subgoal_y ||
                    res.subgoal_index !== want.subgoal_index)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                    begin
                        $display("result %0d: want status %0d x %0d y %0d index %0d",
                                 results_seen, want.status, want.subgoal_x, want.subgoal_y,
                                 want.subgoal_index);
                        $display("result %0d: got  status %0d x %0d y %0d index %0d",
                                 results_seen, res.status, res.subgoal_x, res.subgoal_y,
                                 res.subgoal_index);
                    end
                end
            end
        end
    end

    // watchdog on cycles with no beat moving either way
    always @(posedge clk)
    begin
        if (!rst_n || (cmd_valid && !cmd_stall) || (res_valid && !res_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("lookahead_subgoal_selector: mismatch");
            $finish;
        end
    end

    initial
    begin
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        test_goal_and_ring_cases();
        test_register_extremes();
        test_index_saturation();
        test_random_paths(100, lss_pkg::GOAL_TOL_RESET, lss_pkg::SUBGOAL_TOL_RESET,
                          lss_pkg::HORIZON_RESET, IDLE_NONE);
        test_random_paths(100, 24'd37, 24'd500, 24'd1500, IDLE_SENDER);
        test_random_paths(100, 24'd16384, 24'd262144, 24'd1048576, IDLE_RECEIVER);
        test_random_paths(100, 24'd1000, 24'd6000, 24'd2500, IDLE_BOTH);
        test_random_paths(100, lss_pkg::GOAL_TOL_RESET, lss_pkg::SUBGOAL_TOL_RESET,
                          lss_pkg::HORIZON_RESET, IDLE_BOTH);
        test_random_paths(100, 24'd16384, 24'd262144, 24'd1048576, IDLE_SENDER);
        test_random_paths(100, 24'd37, 24'd500, 24'd1500, IDLE_RECEIVER);
        test_random_paths(100, 24'd1000, 24'd6000, 24'd2500, IDLE_NONE);

        set_idling(IDLE_NONE);
        wait_results_drained();
        if (mismatch_count == 0 && pending_subgoals.size() == 0)
            $display("lookahead_subgoal_selector: match");
        else
            $display("lookahead_subgoal_selector: mismatch");
        $finish;
    end

endmodule
